@@ rtl/fbpa_pkg.sv @@
// Shared types and codes for the fixed block pool allocator.
package fbpa_pkg;

   typedef logic [15:0] size_type;
   typedef logic [7:0]  slot_type;

   typedef logic [1:0] op_type;
   localparam op_type OP_INIT  = 2'd0;
   localparam op_type OP_ALLOC = 2'd1;
   localparam op_type OP_FREE  = 2'd2;

   typedef logic [1:0] status_type;
   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_FULL    = 2'd1;
   localparam status_type ST_INVALID = 2'd2;
   localparam status_type ST_NOCONF  = 2'd3;

   localparam logic REG_TOTAL_SIZE  = 1'b0;
   localparam logic REG_OBJECT_SIZE = 1'b1;

endpackage

@@ rtl/fbpa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module fbpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/fixed_block_pool_allocator_top.sv @@
// Fixed-size block pool allocator: free-slot FIFO, allocated map, iterative divider.
//
// Steps: allocate takes the slot at the head of the free queue, marks it in the map and
// answers. Free runs the 16-bit bit-serial restoring divider, then a range check, a map
// read and the update. A free whose index is out of range answers after the range check.
// Init runs the divide for the slot count, a step to cap it, then a sweep that clears
// the allocated map and loads the free queue one slot per cycle. Init without a
// configured size and allocate from an empty pool answer straight from idle. The next
// word can be accepted in the cycle after the result is loaded.
// After reset the block runs the same sweep over all MAX_SLOTS map entries and
// holds req_ready low meanwhile; configuration writes are taken at any time.
// One word is in work at a time; a finished result waits in the output register
// while the next word is accepted.
module fixed_block_pool_allocator_top #(
   parameter int MAX_SLOTS = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  fbpa_pkg::op_type       req_operation,
   input  fbpa_pkg::size_type     req_byte_offset,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output fbpa_pkg::status_type   rsp_status,
   output fbpa_pkg::slot_type     rsp_slot_index,
   output fbpa_pkg::size_type     rsp_slot_offset,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [2:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);
   import fbpa_pkg::*;

   localparam int AW = $clog2(MAX_SLOTS);
   localparam int CW = $clog2(MAX_SLOTS + 1);
   localparam logic [15:0]   MAX16     = 16'(MAX_SLOTS);
   localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_SLOTS - 1);
   localparam logic [CW-1:0] MAXC      = CW'(MAX_SLOTS);

   localparam logic [2:0] S_CLEAR    = 3'd0;
   localparam logic [2:0] S_IDLE     = 3'd1;
   localparam logic [2:0] S_DIV      = 3'd2;
   localparam logic [2:0] S_DIV_END  = 3'd3;
   localparam logic [2:0] S_ALLOC_RD = 3'd4;
   localparam logic [2:0] S_FREE_CHK = 3'd5;
   localparam logic [2:0] S_DONE     = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] sweep_ff, sweep_in;
   logic [3:0]    div_cnt_ff, div_cnt_in;
   logic          init_ff, init_in;
   op_type        op_ff, op_in;
   size_type      dvd_ff, dvd_in;
   size_type      rem_ff, rem_in;
   logic [CW-1:0] n_ff, n_in;
   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   size_type      total_size_ff, total_size_in;
   size_type      object_size_ff, object_size_in;

   status_type    res_status_ff, res_status_in;
   slot_type      res_index_ff, res_index_in;
   size_type      res_offset_ff, res_offset_in;

   logic          rsp_valid_ff, rsp_valid_in;
   status_type    rsp_status_ff, rsp_status_in;
   slot_type      rsp_index_ff, rsp_index_in;
   size_type      rsp_offset_ff, rsp_offset_in;

   logic          q_wr_en;
   logic [AW-1:0] q_wr_addr;
   slot_type      q_wr_data;
   slot_type      q_rd_data;
   logic          m_wr_en;
   logic [AW-1:0] m_wr_addr;
   logic          m_wr_data;
   logic          m_rd_data;

   logic [16:0]   rem_sh;
   logic          div_ge;
   logic [16:0]   div_diff;
   size_type      q_cap;
   size_type      alloc_idx16;
   size_type      sweep16;
   size_type      mul_a;
   logic [31:0]   prod;
   logic          csr_wr;

   fbpa_ram #(.WIDTH(8), .DEPTH(MAX_SLOTS)) u_queue (
      .clock   (clock),
      .wr_en   (q_wr_en),
      .wr_addr (q_wr_addr),
      .wr_data (q_wr_data),
      .rd_addr (head_ff),
      .rd_data (q_rd_data)
   );

   fbpa_ram #(.WIDTH(1), .DEPTH(MAX_SLOTS)) u_map (
      .clock   (clock),
      .wr_en   (m_wr_en),
      .wr_addr (m_wr_addr),
      .wr_data (m_wr_data),
      .rd_addr (dvd_ff[AW-1:0]),
      .rd_data (m_rd_data)
   );

   assign rem_sh      = {rem_ff, dvd_ff[15]};
   assign div_ge      = rem_sh >= {1'b0, object_size_ff};
   assign div_diff    = rem_sh - {1'b0, object_size_ff};
   assign q_cap       = (dvd_ff > MAX16) ? MAX16 : dvd_ff;
   assign alloc_idx16 = 16'(q_rd_data);
   assign sweep16     = 16'(sweep_ff);
   assign mul_a       = (state_ff == S_ALLOC_RD) ? alloc_idx16 : dvd_ff;
   assign prod        = mul_a * object_size_ff;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = {16'd0, (csr_paddr[2] == REG_OBJECT_SIZE) ? object_size_ff
                                                                   : total_size_ff};

   always_comb begin
      total_size_in  = total_size_ff;
      object_size_in = object_size_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_TOTAL_SIZE:  total_size_in  = csr_pwdata[15:0];
            REG_OBJECT_SIZE: object_size_in = csr_pwdata[15:0];
            default:         total_size_in  = total_size_ff;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      sweep_in      = sweep_ff;
      div_cnt_in    = div_cnt_ff;
      init_in       = init_ff;
      op_in         = op_ff;
      dvd_in        = dvd_ff;
      rem_in        = rem_ff;
      n_in          = n_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      res_offset_in = res_offset_ff;
      q_wr_en       = 1'b0;
      q_wr_addr     = tail_ff;
      q_wr_data     = dvd_ff[7:0];
      m_wr_en       = 1'b0;
      m_wr_addr     = dvd_ff[AW-1:0];
      m_wr_data     = 1'b0;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_offset_in = rsp_offset_ff;

      unique case (state_ff)
         S_CLEAR: begin
            m_wr_en   = 1'b1;
            m_wr_addr = sweep_ff;
            m_wr_data = 1'b0;
            if (init_ff && (sweep16 < 16'(n_ff))) begin
               q_wr_en   = 1'b1;
               q_wr_addr = sweep_ff;
               q_wr_data = sweep16[7:0];
            end
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == LAST_SLOT) begin
               sweep_in = '0;
               init_in  = 1'b0;
               if (init_ff) begin
                  head_in       = '0;
                  tail_in       = (n_ff == MAXC) ? '0 : n_ff[AW-1:0];
                  count_in      = n_ff;
                  res_status_in = ST_OK;
                  res_index_in  = '0;
                  res_offset_in = '0;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in      = req_operation;
               rem_in     = '0;
               div_cnt_in = '0;
               res_index_in  = '0;
               res_offset_in = '0;
               unique case (req_operation)
                  OP_INIT: begin
                     if (total_size_ff == '0) begin
                        res_status_in = ST_NOCONF;
                        state_in      = S_DONE;
                     end else begin
                        dvd_in   = total_size_ff;
                        state_in = S_DIV;
                     end
                  end
                  OP_ALLOC: begin
                     if (count_ff == '0) begin
                        res_status_in = ST_FULL;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_ALLOC_RD;
                     end
                  end
                  OP_FREE: begin
                     dvd_in   = req_byte_offset;
                     state_in = S_DIV;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_DIV: begin
            dvd_in     = {dvd_ff[14:0], div_ge};
            rem_in     = div_ge ? div_diff[15:0] : rem_sh[15:0];
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == 4'd15) begin
               state_in = S_DIV_END;
            end
         end
         S_DIV_END: begin
            if (op_ff == OP_INIT) begin
               n_in     = q_cap[CW-1:0];
               init_in  = 1'b1;
               sweep_in = '0;
               state_in = S_CLEAR;
            end else if (dvd_ff >= MAX16) begin
               res_status_in = ST_INVALID;
               res_index_in  = dvd_ff[7:0];
               res_offset_in = '0;
               state_in      = S_DONE;
            end else begin
               state_in = S_FREE_CHK;
            end
         end
         S_ALLOC_RD: begin
            m_wr_en       = 1'b1;
            m_wr_addr     = alloc_idx16[AW-1:0];
            m_wr_data     = 1'b1;
            head_in       = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
            count_in      = count_ff - 1'b1;
            res_status_in = ST_OK;
            res_index_in  = q_rd_data;
            res_offset_in = prod[15:0];
            state_in      = S_DONE;
         end
         S_FREE_CHK: begin
            res_index_in = dvd_ff[7:0];
            if (!m_rd_data) begin
               res_status_in = ST_INVALID;
               res_offset_in = '0;
            end else begin
               m_wr_en   = 1'b1;
               m_wr_addr = dvd_ff[AW-1:0];
               m_wr_data = 1'b0;
               if (count_ff != MAXC) begin
                  q_wr_en  = 1'b1;
                  tail_in  = (tail_ff == LAST_SLOT) ? '0 : tail_ff + 1'b1;
                  count_in = count_ff + 1'b1;
               end
               res_status_in = ST_OK;
               res_offset_in = prod[15:0];
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_index_in  = res_index_ff;
               rsp_offset_in = res_offset_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         sweep_ff       <= '0;
         div_cnt_ff     <= '0;
         init_ff        <= 1'b0;
         head_ff        <= '0;
         tail_ff        <= '0;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         total_size_ff  <= 16'd0;
         object_size_ff <= 16'd4;
      end else begin
         state_ff       <= state_in;
         sweep_ff       <= sweep_in;
         div_cnt_ff     <= div_cnt_in;
         init_ff        <= init_in;
         head_ff        <= head_in;
         tail_ff        <= tail_in;
         count_ff       <= count_in;
         rsp_valid_ff   <= rsp_valid_in;
         total_size_ff  <= total_size_in;
         object_size_ff <= object_size_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      dvd_ff        <= dvd_in;
      rem_ff        <= rem_in;
      n_ff          <= n_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      res_offset_ff <= res_offset_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_slot_index  = rsp_index_ff;
   assign rsp_slot_offset = rsp_offset_ff;

endmodule
